// ===== hw/rtl/bsc_pkg.sv =====
// Shared types and constants for the banked SRAM cartridge mapper.
// No dependencies; used by bsc_ctrl, bsc_sram and the top level.
package bsc_pkg;

    localparam int SRAM_BYTES = 32768;
    localparam int SRAM_AW    = $clog2(SRAM_BYTES);

    // Control latch as written to $DE00-$DEFF, MSB first.
    typedef struct packed {
        logic       exrom;
        logic       game;
        logic       sram_visible;
        logic       sram_write_on;
        logic       io_locked;
        logic [2:0] bank;
    } latch_t;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_16K     = 2'd0;
    localparam mode_t MODE_8K      = 2'd1;
    localparam mode_t MODE_ULTIMAX = 2'd2;
    localparam mode_t MODE_OFF     = 2'd3;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // 8 KiB regions, bus_address[15:13]
    typedef logic [2:0] region_t;

    localparam region_t REGION_4000 = 3'd2;
    localparam region_t REGION_6000 = 3'd3;
    localparam region_t REGION_8000 = 3'd4;
    localparam region_t REGION_A000 = 3'd5;
    localparam region_t REGION_E000 = 3'd7;

    // I/O page holding the latch, bus_address[15:8]
    localparam logic [7:0] LATCH_PAGE = 8'hDE;

    typedef struct packed {
        logic                 we;
        logic                 re;
        logic [SRAM_AW-1:0]   addr;
        logic [7:0]           wdata;
    } sram_req_t;

    typedef struct packed {
        logic  drives_bus;
        logic  write_route;
        logic  window_writable;
        mode_t mode;
        logic  game;
        logic  exrom;
    } status_t;

    typedef struct packed {
        sram_req_t req;
        logic      use_sram;
        status_t   status;
    } ctrl_t;

endpackage

// ===== hw/rtl/bsc_ctrl.sv =====
// Control latch and address decode for the banked SRAM cartridge mapper.
// Depends on bsc_pkg.
module bsc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic           opcode,
    input  logic [15:0]    bus_address,
    input  logic [7:0]     write_data,
    output bsc_pkg::ctrl_t ctl
);

    bsc_pkg::latch_t  latch_reg;
    bsc_pkg::latch_t  latch_next;
    bsc_pkg::region_t region;
    bsc_pkg::mode_t   mode_cur;
    bsc_pkg::mode_t   mode_new;
    logic             is_write;
    logic             low_win;
    logic             high_win;
    logic             wr_sram;
    logic             rd_low;
    logic             rd_high;
    logic             rd_sram;
    logic             load;
    logic             in_win;
    logic [bsc_pkg::SRAM_AW-1:0] offset;

    assign region   = bus_address[15:13];
    assign is_write = (opcode == bsc_pkg::OP_WRITE);
    assign mode_cur = {latch_reg.exrom, latch_reg.game};

    assign low_win  = (region == bsc_pkg::REGION_4000) || (region == bsc_pkg::REGION_8000);
    assign high_win = (region == bsc_pkg::REGION_6000) || (region == bsc_pkg::REGION_A000)
                   || (region == bsc_pkg::REGION_E000);

    assign wr_sram = is_write && latch_reg.sram_write_on
                  && (mode_cur != bsc_pkg::MODE_OFF) && (low_win || high_win);

    assign rd_low  = (region == bsc_pkg::REGION_8000);
    assign rd_high = (region == bsc_pkg::REGION_A000) || (region == bsc_pkg::REGION_E000);
    assign rd_sram = !is_write && latch_reg.sram_visible && (rd_low || rd_high);

    // a write that hits SRAM never reaches the latch
    assign load = is_write && !wr_sram && (bus_address[15:8] == bsc_pkg::LATCH_PAGE)
               && !latch_reg.io_locked;

    assign latch_next = load ? bsc_pkg::latch_t'(write_data) : latch_reg;
    assign mode_new   = {latch_next.exrom, latch_next.game};

    // window select in bit 13, bank bit 0 picks the 16 KiB half
    assign offset = {latch_reg.bank[0], (wr_sram ? high_win : rd_high), bus_address[12:0]};

    always_comb
    begin
        case (mode_new)
            bsc_pkg::MODE_16K:     in_win = (bus_address[15:14] == 2'b10);
            bsc_pkg::MODE_8K:      in_win = (region == bsc_pkg::REGION_8000);
            bsc_pkg::MODE_ULTIMAX: in_win = (region == bsc_pkg::REGION_8000)
                                         || (region == bsc_pkg::REGION_E000);
            default:               in_win = 1'b0;
        endcase
    end

    always_comb
    begin
        ctl.req.we                 = wr_sram;
        ctl.req.re                 = rd_sram;
        ctl.req.addr               = offset;
        ctl.req.wdata              = write_data;
        ctl.use_sram               = rd_sram;
        ctl.status.drives_bus      = latch_next.sram_visible && in_win;
        ctl.status.write_route     = latch_next.sram_write_on
                                  && (mode_new != bsc_pkg::MODE_OFF)
                                  && (bus_address[15:14] == 2'b01);
        ctl.status.window_writable = latch_next.sram_write_on && in_win;
        ctl.status.mode            = mode_new;
        ctl.status.game            = latch_next.game;
        ctl.status.exrom           = latch_next.exrom;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg <= '0;
        end
        else if (accept && load)
        begin
            latch_reg <= latch_next;
        end
    end

endmodule

// ===== hw/rtl/bsc_sram.sv =====
// 32 KiB cartridge SRAM, one access a cycle, registered read data,
// with a zero-fill sweep after reset. Depends on bsc_pkg.
module bsc_sram (
    input  logic               clk,
    input  logic               rst_n,
    input  bsc_pkg::sram_req_t req,
    output logic [7:0]         rdata,
    output logic               clear_busy
);

    logic [7:0]                 mem [bsc_pkg::SRAM_BYTES];
    logic [bsc_pkg::SRAM_AW-1:0] clr_addr_reg;
    logic [bsc_pkg::SRAM_AW-1:0] clr_addr_next;
    logic                       clr_busy_reg;
    logic                       clr_busy_next;
    logic [7:0]                 rdata_reg;
    logic                       we;
    logic [bsc_pkg::SRAM_AW-1:0] waddr;
    logic [7:0]                 wdata;

    assign we    = clr_busy_reg || req.we;
    assign waddr = clr_busy_reg ? clr_addr_reg : req.addr;
    assign wdata = clr_busy_reg ? 8'h00 : req.wdata;

    assign clr_addr_next = clr_addr_reg + 1'b1;
    assign clr_busy_next = clr_busy_reg && (clr_addr_reg != '1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata      = rdata_reg;
    assign clear_busy = clr_busy_reg;

endmodule

// ===== hw/rtl/banked_sram_cartridge_mapper.sv =====
// Banked SRAM cartridge mapper, top level: handshake pipeline around the
// control latch/decode (bsc_ctrl) and the SRAM (bsc_sram). Depends on bsc_pkg.
//
// One bus transaction in, one result transaction out. The block takes a
// transaction every cycle unless in_ready is low, as during the SRAM sweep
// or while stage 1 waits on a full output register. The SRAM is read at
// the acceptance edge; out_valid rises once the result reaches the output
// register. Latch and SRAM are both updated at the acceptance edge, so a
// read following a write to the same SRAM byte in the next cycle already
// sees the new byte. After reset the SRAM is swept to zero one byte a cycle
// until all 32768 bytes are cleared. Status outputs (mode, lines, bus drive,
// write routing) reflect the latch after the transaction has been applied.

module banked_sram_cartridge_mapper (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] bus_address,
    input  logic [7:0]  write_data,
    input  logic [7:0]  open_bus_data,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic        drives_bus,
    output logic        write_route,
    output logic        window_writable,
    output logic [1:0]  mode_out,
    output logic        game_line,
    output logic        exrom_line
);

    bsc_pkg::ctrl_t   ctl;
    logic [7:0]       sram_rdata;
    logic             clear_busy;
    logic             accept;

    // stage 1: SRAM read in flight
    logic             s1_valid_reg;
    logic             s1_use_sram_reg;
    logic [7:0]       s1_rd_reg;
    bsc_pkg::status_t s1_status_reg;
    logic             s1_adv;

    // stage 2: output register
    logic             out_valid_reg;
    logic [7:0]       out_rd_reg;
    bsc_pkg::status_t out_status_reg;

    // output register frees up when empty or being taken
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !clear_busy && (!s1_valid_reg || s1_adv);
    assign accept   = in_valid && in_ready;

    bsc_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .opcode      (opcode),
        .bus_address (bus_address),
        .write_data  (write_data),
        .ctl         (ctl)
    );

    bsc_pkg::sram_req_t sram_req;

    always_comb
    begin
        sram_req    = ctl.req;
        sram_req.we = ctl.req.we && accept;
        sram_req.re = ctl.req.re && accept;
    end

    bsc_sram u_sram (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (sram_req),
        .rdata      (sram_rdata),
        .clear_busy (clear_busy)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_use_sram_reg <= ctl.use_sram;
            // writes return zero, reads off SRAM return the open-bus byte
            s1_rd_reg       <= (opcode == bsc_pkg::OP_WRITE) ? 8'h00 : open_bus_data;
            s1_status_reg   <= ctl.status;
        end
        if (s1_adv)
        begin
            out_rd_reg     <= s1_use_sram_reg ? sram_rdata : s1_rd_reg;
            out_status_reg <= s1_status_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = out_rd_reg;
    assign drives_bus      = out_status_reg.drives_bus;
    assign write_route     = out_status_reg.write_route;
    assign window_writable = out_status_reg.window_writable;
    assign mode_out        = out_status_reg.mode;
    assign game_line       = out_status_reg.game;
    assign exrom_line      = out_status_reg.exrom;

endmodule

// ===== sim/banked_sram_cartridge_mapper_test.sv =====
// Self-checking testbench for banked_sram_cartridge_mapper: directed and random bus
// transactions, mirrored control latch and SRAM, result-by-result comparison.
// Depends on bsc_pkg and the banked_sram_cartridge_mapper RTL.
`timescale 1ns / 1ps

module banked_sram_cartridge_mapper_test;

    // Run shape
    localparam int RANDOM_ITEMS = 450;
    localparam int PRESSURE_AT  = 150;   // random transaction at which the hold-off starts
    localparam int HOLD_CYCLES  = 300;   // receiver hold-off, long enough to fill the pipe
    localparam int DRAIN_CYCLES = 8;     // margin after the last result is taken
    localparam int MAX_REPORTS  = 10;
    // Slowest correct run: the SRAM sweep plus ~480 transactions, each with idle
    // stretches on both sides, plus the hold-off; the limit leaves wide room.
    localparam int unsigned CYCLE_LIMIT = 400000;

    // One result transaction as it leaves the block
    typedef struct packed {
        logic [7:0]       read_data;
        bsc_pkg::status_t status;
    } access_result_t;

    // Mirror of the mapper: control latch, SRAM and the queue of results still due.
    class cart_mirror;
        bsc_pkg::latch_t ctl;
        logic [7:0]      sram [bsc_pkg::SRAM_BYTES];
        access_result_t  due_results [$];
        int              mismatches;

        function new();
            ctl = '0;
            foreach (sram[i])
                sram[i] = 8'h00;
            mismatches = 0;
        endfunction

        function bsc_pkg::mode_t mode();
            return bsc_pkg::mode_t'({ctl.exrom, ctl.game});
        endfunction

        // Low window: offset within the bank half, bit 13 clear
        function logic [bsc_pkg::SRAM_AW-1:0] low_addr(input logic [15:0] a);
            return {ctl.bank[0], 1'b0, a[12:0]};
        endfunction

        function logic [bsc_pkg::SRAM_AW-1:0] high_addr(input logic [15:0] a);
            return {ctl.bank[0], 1'b1, a[12:0]};
        endfunction

        function logic in_mode_window(input logic [15:0] a);
            bsc_pkg::region_t r;
            r = a[15:13];
            case (mode())
                bsc_pkg::MODE_16K:
                    return (r == bsc_pkg::REGION_8000) || (r == bsc_pkg::REGION_A000);
                bsc_pkg::MODE_8K:
                    return (r == bsc_pkg::REGION_8000);
                bsc_pkg::MODE_ULTIMAX:
                    return (r == bsc_pkg::REGION_8000) || (r == bsc_pkg::REGION_E000);
                default:
                    return 1'b0;
            endcase
        endfunction

        function void note_access(input logic op, input logic [15:0] a,
                                  input logic [7:0] wd, input logic [7:0] ob);
            bsc_pkg::region_t r;
            logic             to_sram;
            access_result_t   res;
            r       = a[15:13];
            to_sram = 1'b0;
            res     = '0;
            if (op == bsc_pkg::OP_WRITE)
            begin
                if (ctl.sram_write_on && mode() != bsc_pkg::MODE_OFF)
                begin
                    if (r == bsc_pkg::REGION_4000 || r == bsc_pkg::REGION_8000)
                    begin
                        sram[low_addr(a)] = wd;
                        to_sram = 1'b1;
                    end
                    else if (r == bsc_pkg::REGION_6000 || r == bsc_pkg::REGION_A000 ||
                             r == bsc_pkg::REGION_E000)
                    begin
                        sram[high_addr(a)] = wd;
                        to_sram = 1'b1;
                    end
                end
                if (!to_sram && a[15:8] == bsc_pkg::LATCH_PAGE && !ctl.io_locked)
                    ctl = bsc_pkg::latch_t'(wd);
            end
            else
            begin
                res.read_data = ob;
                if (ctl.sram_visible)
                begin
                    if (r == bsc_pkg::REGION_8000)
                        res.read_data = sram[low_addr(a)];
                    else if (r == bsc_pkg::REGION_A000 || r == bsc_pkg::REGION_E000)
                        res.read_data = sram[high_addr(a)];
                end
            end
            // status reflects the latch after this access
            res.status.drives_bus      = ctl.sram_visible && in_mode_window(a);
            res.status.write_route     = ctl.sram_write_on && mode() != bsc_pkg::MODE_OFF &&
                                         (r == bsc_pkg::REGION_4000 ||
                                          r == bsc_pkg::REGION_6000);
            res.status.window_writable = ctl.sram_write_on && in_mode_window(a);
            res.status.mode            = mode();
            res.status.game            = ctl.game;
            res.status.exrom           = ctl.exrom;
            due_results.push_back(res);
        endfunction

        function void check_result(input access_result_t got);
            access_result_t exp;
            if (due_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result transaction with nothing due: rd=%h st=%b",
                             $realtime, got.read_data, got.status);
                return;
            end
            exp = due_results.pop_front();
            if (got !== exp)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("[%0t] mismatch (expected/actual): read_data %h/%h drives_bus %b/%b",
                             $realtime, exp.read_data, got.read_data,
                             exp.status.drives_bus, got.status.drives_bus);
                    $display({"    write_route %b/%b window_writable %b/%b mode %0d/%0d",
                              " game %b/%b exrom %b/%b"} == "" ? "" :
                             "    write_route %b/%b window_writable %b/%b", 
                             exp.status.write_route, got.status.write_route,
                             exp.status.window_writable, got.status.window_writable);
                    $display("    mode %0d/%0d game %b/%b exrom %b/%b",
                             exp.status.mode, got.status.mode,
                             exp.status.game, got.status.game,
                             exp.status.exrom, got.status.exrom);
                end
            end
        endfunction
    endclass

    // Clock, reset and block ports; every input known from time zero
    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic        in_ready;
    logic        opcode        = bsc_pkg::OP_READ;
    logic [15:0] bus_address   = 16'h0000;
    logic [7:0]  write_data    = 8'h00;
    logic [7:0]  open_bus_data = 8'h00;
    logic        out_valid;
    logic        out_ready     = 1'b0;
    logic [7:0]  read_data;
    logic        drives_bus;
    logic        write_route;
    logic        window_writable;
    logic [1:0]  mode_out;
    logic        game_line;
    logic        exrom_line;

    cart_mirror  mirror;
    bit          hold_req  = 1'b0;   // sender asks for the long receiver hold-off
    bit          hold_done = 1'b0;
    bit          tx_calm   = 1'b0;   // stretch with no sender idling
    int unsigned cycle_count = 0;

    banked_sram_cartridge_mapper u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .bus_address     (bus_address),
        .write_data      (write_data),
        .open_bus_data   (open_bus_data),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .read_data       (read_data),
        .drives_bus      (drives_bus),
        .write_route     (write_route),
        .window_writable (window_writable),
        .mode_out        (mode_out),
        .game_line       (game_line),
        .exrom_line      (exrom_line)
    );

    always #5 clk = ~clk;

    // Idle stretch: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offer one bus transaction and hold it until the block takes it.
    // Inputs change only at rising edges, by nonblocking assignment, so the
    // monitor below always sees the values that were present at the edge.
    task automatic send_access(input logic op, input logic [15:0] a,
                               input logic [7:0] wd, input logic [7:0] ob);
        int gap;
        if ($urandom_range(0, 39) == 0)
            tx_calm = !tx_calm;
        gap = tx_calm ? 0 : idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        opcode        <= op;
        bus_address   <= a;
        write_data    <= wd;
        open_bus_data <= ob;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Random transaction. Most of them are latch loads and accesses to the SRAM
    // windows, with offsets drawn often from a small pool at both ends of the
    // window so that reads land on bytes written earlier; the rest is noise.
    // The IO lock bit is kept clear here: once set, it would freeze the latch
    // for the rest of the run, so the lock is exercised at the very end.
    task automatic send_random_access();
        int               kind;
        logic             op;
        logic [15:0]      a;
        logic [7:0]       wd;
        logic [7:0]       ob;
        logic [12:0]      offs;
        bsc_pkg::region_t r;
        kind = $urandom_range(0, 99);
        wd   = 8'($urandom_range(0, 255));
        ob   = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0)
            offs = ($urandom_range(0, 1) == 0) ? 13'($urandom_range(0, 7))
                                               : 13'($urandom_range(13'h1FF8, 13'h1FFF));
        else
            offs = 13'($urandom_range(0, 13'h1FFF));
        case ($urandom_range(0, 4))
            0:       r = bsc_pkg::REGION_4000;
            1:       r = bsc_pkg::REGION_6000;
            2:       r = bsc_pkg::REGION_8000;
            3:       r = bsc_pkg::REGION_A000;
            default: r = bsc_pkg::REGION_E000;
        endcase
        if (kind < 12)
        begin
            // latch load, mostly with SRAM write and select on
            op = bsc_pkg::OP_WRITE;
            a  = {bsc_pkg::LATCH_PAGE, 8'($urandom_range(0, 255))};
            wd[3] = 1'b0;
            if ($urandom_range(0, 3) != 0)
                wd[5:4] = 2'b11;
        end
        else if (kind < 47)
        begin
            op = bsc_pkg::OP_WRITE;
            a  = {r, offs};
        end
        else if (kind < 82)
        begin
            op = bsc_pkg::OP_READ;
            a  = {r, offs};
        end
        else
        begin
            op = 1'($urandom_range(0, 1));
            a  = 16'($urandom_range(0, 16'hFFFF));
            if (op == bsc_pkg::OP_WRITE && a[15:8] == bsc_pkg::LATCH_PAGE)
                wd[3] = 1'b0;
        end
        send_access(op, a, wd, ob);
    endtask

    // Monitor: check results first, then note the transaction taken at this edge,
    // so a result can never be matched against a transaction of the same edge.
    always @(posedge clk)
    begin
        access_result_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.read_data              = read_data;
                got.status.drives_bus      = drives_bus;
                got.status.write_route     = write_route;
                got.status.window_writable = window_writable;
                got.status.mode            = mode_out;
                got.status.game            = game_line;
                got.status.exrom           = exrom_line;
                mirror.check_result(got);
            end
            if (in_valid && in_ready)
                mirror.note_access(opcode, bus_address, write_data, open_bus_data);
        end
    end

    // Receiver: random ready with calm stretches, plus one long hold-off while
    // the sender keeps offering, so the block fills and drops in_ready.
    initial
    begin : receiver
        int   n;
        logic lvl;
        bit   calm;
        calm = 1'b0;
        forever
        begin
            if (hold_req && !hold_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                if ($urandom_range(0, 49) == 0)
                    calm = !calm;
                if (calm || $urandom_range(0, 3) != 0)
                begin
                    lvl = 1'b1;
                    n   = $urandom_range(1, 4);
                end
                else
                begin
                    lvl = 1'b0;
                    n   = 1 + idle_len();
                end
                out_ready <= lvl;
                repeat (n) @(posedge clk);
            end
        end
    end

    // Watchdog
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** banked_sram_cartridge_mapper: FAILED **");
        $finish;
    end

    // Main sequence. The block sweeps its SRAM after reset, so the first
    // transaction simply waits on in_ready.
    initial
    begin : stimulus
        mirror = new();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset state: 16K mode, SRAM hidden, reads give the open bus
        send_access(bsc_pkg::OP_READ,  16'h0000, 8'h00, 8'hFF);
        send_access(bsc_pkg::OP_READ,  16'h8000, 8'hFF, 8'h00);
        // SRAM write and select on, bank 0, 16K
        send_access(bsc_pkg::OP_WRITE, 16'hDE00, 8'h30, 8'h00);
        send_access(bsc_pkg::OP_WRITE, 16'h8000, 8'hA5, 8'h00);
        send_access(bsc_pkg::OP_READ,  16'h8000, 8'h00, 8'h00);  // read straight after write
        send_access(bsc_pkg::OP_WRITE, 16'hBFFF, 8'h5A, 8'hFF);
        send_access(bsc_pkg::OP_READ,  16'hBFFF, 8'h00, 8'hFF);
        send_access(bsc_pkg::OP_WRITE, 16'h4000, 8'hFF, 8'h00);  // routed to both
        send_access(bsc_pkg::OP_WRITE, 16'h7FFF, 8'h01, 8'h00);
        send_access(bsc_pkg::OP_READ,  16'h9FFF, 8'h00, 8'h3C);
        // bank 1, 8K mode, top of the latch page
        send_access(bsc_pkg::OP_WRITE, 16'hDEFF, 8'h71, 8'h00);
        send_access(bsc_pkg::OP_WRITE, 16'hE000, 8'h3C, 8'h00);
        send_access(bsc_pkg::OP_READ,  16'hFFFF, 8'h00, 8'hAA);
        // bank 6 (half 0), Ultimax
        send_access(bsc_pkg::OP_WRITE, 16'hDE80, 8'hB6, 8'h00);
        send_access(bsc_pkg::OP_READ,  16'hE000, 8'h00, 8'h55);
        // off mode: writes miss SRAM, but a selected SRAM still answers reads
        send_access(bsc_pkg::OP_WRITE, 16'hDE00, 8'hF0, 8'h00);
        send_access(bsc_pkg::OP_WRITE, 16'h8000, 8'h11, 8'h00);
        send_access(bsc_pkg::OP_READ,  16'h8000, 8'h00, 8'hC3);
        // select only, writes disabled
        send_access(bsc_pkg::OP_WRITE, 16'hDE00, 8'h20, 8'h00);
        send_access(bsc_pkg::OP_WRITE, 16'h8000, 8'h77, 8'h00);
        send_access(bsc_pkg::OP_READ,  16'h8000, 8'h00, 8'h00);
        // just outside the latch page: no load
        send_access(bsc_pkg::OP_WRITE, 16'hDDFF, 8'h30, 8'h00);
        send_access(bsc_pkg::OP_WRITE, 16'hDF00, 8'h30, 8'hFF);
        send_access(bsc_pkg::OP_READ,  16'hC000, 8'h00, 8'h81);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == PRESSURE_AT)
                hold_req = 1'b1;
            send_random_access();
        end

        // IO lock: set it, then every later latch load is ignored
        send_access(bsc_pkg::OP_WRITE, 16'hDE00, 8'h3F, 8'h00);
        send_access(bsc_pkg::OP_WRITE, 16'hDE40, 8'hC0, 8'h00);
        send_access(bsc_pkg::OP_WRITE, 16'hA001, 8'h99, 8'h00);
        send_access(bsc_pkg::OP_READ,  16'hA001, 8'h00, 8'h00);
        send_access(bsc_pkg::OP_WRITE, 16'hDEFF, 8'h00, 8'h00);
        send_access(bsc_pkg::OP_READ,  16'h4000, 8'h00, 8'hE7);
        send_access(bsc_pkg::OP_READ,  16'h8001, 8'h00, 8'h18);

        // one edge first so the monitor has noted the last transaction
        in_valid <= 1'b0;
        @(posedge clk);
        while (mirror.due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mirror.mismatches == 0 && mirror.due_results.size() == 0)
            $display("** banked_sram_cartridge_mapper: PASSED **");
        else
            $display("** banked_sram_cartridge_mapper: FAILED **");
        $finish;
    end

endmodule
